// ===== hw/rtl/sha256_stream_hasher_core_macros.svh =====
// Assertion macros for the SHA-256 stream hasher core.
`ifndef SHA256_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_STREAM_HASHER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SHS_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SHS_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHS_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SHS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg
// Types, constants and round functions shared by the SHA-256 hasher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package shs_pkg;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned DigestWords = 8;
   localparam logic [7:0] PadMark = 8'h80;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_PADW, ST_PADL, ST_EMIT
   } state_type;

   typedef logic [31:0] word_type;

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k [64] = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[idx];
   endfunction

   function automatic word_type init_h(input logic [2:0] idx);
      word_type h [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[idx];
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction
endpackage

// ===== hw/rtl/shs_stream_if.sv =====
// ----------------------------------------------------------------------------
// shs_req_if / shs_rsp_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface shs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last;
   modport source (output valid, data_byte, byte_valid, last, input ready);
   modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface shs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   logic        length_overflow;
   modport source (output valid, digest_word, word_index, last_word, length_overflow,
                   input ready);
   modport sink (input valid, digest_word, word_index, last_word, length_overflow,
                 output ready);
endinterface

// ===== hw/rtl/sha256_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a byte stream, one byte per request beat, digest as 8 beats.
// ----------------------------------------------------------------------------
// Request beats carry one byte, a byte_valid flag and a last marker. Bytes are
// packed into a 16 x 32 block RAM. A beat with byte_valid 0 and last 0 is
// dropped. The 64th byte of a block starts a compression: the LOAD state reads
// the words from the RAM, the ROUND state runs one round a cycle and the ADD
// state adds into the chaining value; req.ready stays low. On last, the
// pad byte and zero words are written one word a cycle, the length goes into
// the final two words, and one or two compressions follow. Then eight
// response beats give the digest, word 0 first, with last_word on word 7.
// Byte beats that fill no block do not stall; a full block stalls for its
// compression. While rsp.ready is low the current digest beat holds and no
// request is taken. Reset (synchronous) restores the initial hash values,
// clears the byte count and overflow flag; the block RAM needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha256_stream_hasher_core_macros.svh"
module sha256_stream_hasher_core (
   input logic  clock,
   input logic  reset,
   shs_req_if.sink   req,
   shs_rsp_if.source rsp
);
   import shs_pkg::*;

   state_type   state_ff, state_in;
   logic [31:0] count_ff, count_in;
   logic        ovf_ff, ovf_in;
   logic        fin_ff, fin_in;
   logic        two_ff, two_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [3:0]  pw_ff, pw_in;
   word_type    chain_ff [8];
   word_type    vars [8];

   logic        we;
   logic [3:0]  waddr, wstrb, raddr;
   word_type    wdata, rdata;
   logic        start, load_en, step;
   logic        take, add_byte;
   logic [5:0]  fill;
   logic [31:0] cnt_p1;

   shs_block_ram u_ram (.clock, .we, .waddr, .wstrb, .wdata, .raddr, .rdata);
   shs_round_unit u_round (.clock, .start, .load_en, .load_word(rdata), .step,
                           .round(cnt_ff[5:0]), .chain_in(chain_ff), .vars_out(vars));

   assign take = req.valid && req.ready;
   assign add_byte = take && req.byte_valid;
   assign cnt_p1 = count_ff + 32'd1;
   assign fill = count_ff[5:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (take) begin
            if (add_byte && cnt_p1[5:0] == 6'd0) state_in = ST_LOAD;
            else if (req.last) state_in = ST_PADW;
         end
         ST_LOAD: if (cnt_ff == 7'd16) state_in = ST_ROUND;
         ST_ROUND: if (cnt_ff == 7'd63) state_in = ST_ADD;
         ST_ADD: begin
            if (!fin_ff) state_in = ST_IDLE;
            else if (two_ff) state_in = ST_PADW;
            else state_in = ST_EMIT;
         end
         ST_PADW: if (pw_ff == 4'd15 || (pw_ff == 4'd13 && !two_ff)) begin
            state_in = two_ff ? ST_LOAD : ST_PADL;
         end
         ST_PADL: if (pw_ff == 4'd15) state_in = ST_LOAD;
         ST_EMIT: if (rsp.ready && cnt_ff[2:0] == 3'd7) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff; ovf_in = ovf_ff; fin_in = fin_ff; two_in = two_ff;
      cnt_in = cnt_ff; pw_in = pw_ff;
      we = 1'b0; waddr = fill[5:2]; wstrb = 4'b0; wdata = '0;
      raddr = cnt_ff[3:0]; start = 1'b0; load_en = 1'b0; step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (add_byte) begin
               we = 1'b1;
               wstrb = 4'b1000 >> fill[1:0];
               wdata = {4{req.data_byte}};
               count_in = cnt_p1;
               if (cnt_p1 == 32'd0) ovf_in = 1'b1;
            end
            if (take && req.last) begin
               fin_in = 1'b1;
               pw_in = add_byte ? cnt_p1[5:2] : fill[5:2];
               two_in = add_byte ? (cnt_p1[5:0] >= 6'd56) : (fill >= 6'd56);
               if (add_byte && cnt_p1[5:0] == 6'd0) begin
                  two_in = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            raddr = cnt_ff[3:0];
            load_en = (cnt_ff != 7'd0);
            start = (cnt_ff == 7'd16);
            cnt_in = (cnt_ff == 7'd16) ? 7'd0 : cnt_ff + 7'd1;
         end
         ST_ROUND: begin
            step = 1'b1;
            cnt_in = cnt_ff + 7'd1;
         end
         ST_ADD: begin
            cnt_in = '0;
            if (fin_ff && two_ff) begin
               two_in = 1'b0;
               pw_in = '0;
            end
         end
         ST_PADW: begin
            we = 1'b1; waddr = pw_ff; wstrb = 4'b1111;
            if (pw_ff == fill[5:2] && fin_ff && cnt_ff == 7'd0) begin
               wstrb = 4'b1111 >> fill[1:0];
               wdata = {PadMark, 24'd0} >> {fill[1:0], 3'b000};
            end
            cnt_in = 7'd1;
            pw_in = pw_ff + 4'd1;
            if (pw_ff == 4'd15 || (pw_ff == 4'd13 && !two_ff)) cnt_in = '0;
         end
         ST_PADL: begin
            we = 1'b1; waddr = pw_ff; wstrb = 4'b1111;
            wdata = (pw_ff == 4'd14) ? {29'd0, count_ff[31:29]} : {count_ff[28:0], 3'b000};
            pw_in = pw_ff + 4'd1;
            cnt_in = '0;
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff[2:0] == 3'd7) begin
                  count_in = '0; ovf_in = 1'b0; fin_in = 1'b0; cnt_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0; ovf_ff <= 1'b0; fin_ff <= 1'b0; two_ff <= 1'b0;
         cnt_ff <= '0; pw_ff <= '0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= init_h(3'(i));
      end else begin
         state_ff <= state_in;
         count_ff <= count_in; ovf_ff <= ovf_in; fin_ff <= fin_in; two_ff <= two_in;
         cnt_ff <= cnt_in; pw_ff <= pw_in;
         if (state_ff == ST_ADD) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + vars[i];
         end
         if (state_ff == ST_EMIT && rsp.ready && cnt_ff[2:0] == 3'd7) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= init_h(3'(i));
         end
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_EMIT);
   assign rsp.digest_word = chain_ff[cnt_ff[2:0]];
   assign rsp.word_index = cnt_ff[2:0];
   assign rsp.last_word = (cnt_ff[2:0] == 3'd7);
   assign rsp.length_overflow = ovf_ff;

   `SHS_ASSERT_IMPL(a_no_ready_busy, clock, reset, rsp.valid |-> !req.ready, "ready while emitting")
   `SHS_ASSERT_IMPL(a_emit_from_add, clock, reset, $rose(rsp.valid) |-> $past(state_ff == ST_ADD), "digest without compression")
   `SHS_ASSERT_IMPL(a_round_bound, clock, reset, (state_ff == ST_ROUND) |-> (cnt_ff < 7'd64), "round counter out of range")
endmodule

// ===== hw/rtl/shs_block_ram.sv =====
// ----------------------------------------------------------------------------
// shs_block_ram
// 16 x 32 block buffer with byte-lane writes and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module shs_block_ram (
   input  logic        clock,
   input  logic        we,
   input  logic [3:0]  waddr,
   input  logic [3:0]  wstrb,
   input  logic [31:0] wdata,
   input  logic [3:0]  raddr,
   output logic [31:0] rdata
);
   logic [31:0] mem [16];
   always_ff @(posedge clock) begin
      if (we) begin
         for (int i = 0; i < 4; i++) begin
            if (wstrb[i]) mem[waddr][8*i +: 8] <= wdata[8*i +: 8];
         end
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== hw/rtl/shs_round_unit.sv =====
// ----------------------------------------------------------------------------
// shs_round_unit
// One SHA-256 round and schedule step per step cycle, over a 16-word window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module shs_round_unit (
   input  logic                clock,
   input  logic                start,
   input  logic                load_en,
   input  shs_pkg::word_type   load_word,
   input  logic                step,
   input  logic [5:0]          round,
   input  shs_pkg::word_type   chain_in [8],
   output shs_pkg::word_type   vars_out [8]
);
   import shs_pkg::*;
   word_type w_ff [16];
   word_type v_ff [8];
   word_type w_new, wt, s0, s1, t1, t2, e, a;

   always_comb begin
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = s1 + w_ff[9] + s0 + w_ff[0];
      wt = (round < 6'd16) ? w_ff[round[3:0]] : w_new;
      e = v_ff[4];
      a = v_ff[0];
      t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
         + ((e & v_ff[5]) ^ (~e & v_ff[6])) + round_k(round) + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= load_word;
      end else if (step && round >= 6'd16) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
      if (start) begin
         v_ff <= chain_in;
      end else if (step) begin
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end
   assign vars_out = v_ff;
endmodule
